// ===== src/wpm_pkg.sv =====
// shared constants, codes and types for the wildcard pattern matcher
`default_nettype none

package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int ROW_W       = MAX_PATTERN + 1;
    localparam int LEN_W       = 6;
    localparam int PAT_W       = 8 * MAX_PATTERN;
    localparam int SCAN_LVLS   = $clog2(ROW_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WORD_BYTES = CFG_DATA_W / 8;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_SECOND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_THIRD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_HIGH     = 3'd4;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // queue depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // pattern view seen by the row update
    typedef struct packed {
        logic [LEN_W-1:0]       len;
        logic [MAX_PATTERN-1:0] star;
        logic [ROW_W-1:0]       init_row;
        logic [ROW_W-1:0]       row_mask;
    } t_cfg_view;

    // one classified text byte
    typedef struct packed {
        logic                   restart;
        logic [MAX_PATTERN-1:0] hit;
    } t_qword;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// ===== src/wildcard_pattern_matcher.sv =====
// wildcard matcher: one text word per cycle while the output is not stalled; an accepted
// word is written to the queue, then its row result is registered in the output stage; the
// match-row register in the back stage carries the row loop through a log-depth star scan
// a 2-entry queue splits input and output handshakes, output is a register stage
// synchronous active-low reset clears queue, row and config registers and sets the start flag
`default_nettype none

module wildcard_pattern_matcher
    import wpm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] text_byte
    input  wire logic [0:0]            i_s_tuser,   // [0] first_byte
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [7:0]            o_m_tdata,   // [0] prefix_matches, [1] any_alive
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PAT_W-1:0] w_pattern;
    t_cfg_view        w_view;
    t_qword           w_push_word;
    t_qword           w_pop_word;
    t_qstat           w_qstat;
    logic             w_push;
    logic             w_pop;
    logic             w_prefix;
    logic             w_alive;

    assign o_cfg_ready = 1'b1;

    wpm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pattern   (w_pattern),
        .o_view      (w_view)
    );

    wpm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_text_byte  (i_s_tdata),
        .i_first_byte (i_s_tuser[0]),
        .i_pattern    (w_pattern),
        .i_q_full     (w_qstat.full),
        .o_ready      (o_s_tready),
        .o_push       (w_push),
        .o_qword      (w_push_word)
    );

    wpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_word),
        .i_pop   (w_pop),
        .o_rdata (w_pop_word),
        .o_stat  (w_qstat)
    );

    wpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_view           (w_view),
        .i_qword          (w_pop_word),
        .i_qstat          (w_qstat),
        .o_pop            (w_pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_prefix_matches (w_prefix),
        .o_any_alive      (w_alive)
    );

    assign o_m_tdata = {6'b0, w_alive, w_prefix};

    // a full match always leaves at least one live prefix
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[0] || o_m_tdata[1]))
        else $error("prefix match without any live prefix");

    // queue status flags never both set
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("queue full and empty at once");

    // a word accepted while none is popped leaves the queue non-empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> !w_qstat.empty)
        else $error("accepted word lost in queue");

endmodule

`default_nettype wire

// ===== src/wpm_cfg.sv =====
// configuration registers and the derived star, initial-row and length masks
`default_nettype none

module wpm_cfg
    import wpm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [PAT_W-1:0]      o_pattern,
    output t_cfg_view                  o_view
);

    logic [LEN_W-1:0]       r_pattern_length;
    logic [PAT_W-1:0]       r_pattern;
    t_cfg_view              r_view;
    t_cfg_view              n_view;
    logic [LEN_W-1:0]       w_len;
    logic [MAX_PATTERN-1:0] w_star;
    logic [SCAN_LVLS:0][MAX_PATTERN-1:0] w_lead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_pattern        <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                REG_BYTES_LOW:      r_pattern[0*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_BYTES_SECOND:   r_pattern[1*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_BYTES_THIRD:    r_pattern[2*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                REG_BYTES_HIGH:     r_pattern[3*CFG_DATA_W +: CFG_DATA_W] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_len = (r_pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                            : r_pattern_length;

    // leading-star closure as a log-depth prefix and
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            w_star[j]    = (r_pattern[8*j +: 8] == STAR_BYTE);
            w_lead[0][j] = w_star[j];
        end
        for (int l = 0; l < SCAN_LVLS; l++) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (j >= (1 << l)) begin
                    w_lead[l+1][j] = w_lead[l][j] & w_lead[l][j - (1 << l)];
                end else begin
                    w_lead[l+1][j] = w_lead[l][j];
                end
            end
        end
    end

    always_comb begin
        n_view.len         = w_len;
        n_view.star        = w_star;
        n_view.init_row[0] = 1'b1;
        n_view.row_mask[0] = 1'b1;
        for (int j = 1; j < ROW_W; j++) begin
            n_view.init_row[j] = w_lead[SCAN_LVLS][j-1] & (LEN_W'(j) <= w_len);
            n_view.row_mask[j] = (LEN_W'(j) <= w_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.len      <= '0;
            r_view.star     <= '0;
            r_view.init_row <= ROW_W'(1);
            r_view.row_mask <= ROW_W'(1);
        end else begin
            r_view <= n_view;
        end
    end

    assign o_pattern = r_pattern;
    assign o_view    = r_view;

endmodule

`default_nettype wire

// ===== src/wpm_front.sv =====
// input side: takes text words, compares against every pattern byte, tracks restart
`default_nettype none

module wpm_front
    import wpm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_first_byte,
    input  wire logic [PAT_W-1:0] i_pattern,
    input  wire logic             i_q_full,
    output logic                  o_ready,
    output logic                  o_push,
    output t_qword                o_qword
);

    logic r_at_start;
    logic n_at_start;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid & !i_q_full;

    always_comb begin
        n_at_start = r_at_start;
        if (o_push) begin
            n_at_start = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

    always_comb begin
        o_qword.restart = i_first_byte | r_at_start;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            o_qword.hit[j] = (i_pattern[8*j +: 8] == i_text_byte) |
                             (i_pattern[8*j +: 8] == ANY_BYTE);
        end
    end

endmodule

`default_nettype wire

// ===== src/wpm_queue.sv =====
// short queue of classified words between the front and back
`default_nettype none

module wpm_queue
    import wpm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qword i_wdata,
    input  wire logic   i_pop,
    output t_qword      o_rdata,
    output t_qstat      o_stat
);

    t_qword             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    assign o_rdata     = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== src/wpm_back.sv =====
// back side: match-row update with a prefix scan over star runs, output register
`default_nettype none

module wpm_back
    import wpm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg_view i_view,
    input  wire t_qword    i_qword,
    input  wire t_qstat    i_qstat,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output logic           o_prefix_matches,
    output logic           o_any_alive
);

    logic [ROW_W-1:0]               r_row;
    logic [ROW_W-1:0]               w_old;
    logic [ROW_W-1:0]               w_next;
    logic [SCAN_LVLS:0][ROW_W-1:0]  w_g;
    logic [SCAN_LVLS:0][ROW_W-1:0]  w_p;
    logic                           r_valid;
    logic                           r_prefix;
    logic                           r_alive;

    assign o_pop = !i_qstat.empty & (!r_valid | i_ready);
    assign w_old = i_qword.restart ? i_view.init_row : r_row;

    // bit j = g | p & bit j-1, where a pattern star passes the lower bit up
    always_comb begin
        w_g[0][0] = 1'b0;
        w_p[0][0] = 1'b0;
        for (int j = 1; j < ROW_W; j++) begin
            w_p[0][j] = i_view.star[j-1];
            w_g[0][j] = i_view.star[j-1] ? w_old[j] : (i_qword.hit[j-1] & w_old[j-1]);
        end
        for (int l = 0; l < SCAN_LVLS; l++) begin
            for (int j = 0; j < ROW_W; j++) begin
                if (j >= (1 << l)) begin
                    w_g[l+1][j] = w_g[l][j] | (w_p[l][j] & w_g[l][j - (1 << l)]);
                    w_p[l+1][j] = w_p[l][j] & w_p[l][j - (1 << l)];
                end else begin
                    w_g[l+1][j] = w_g[l][j];
                    w_p[l+1][j] = w_p[l][j];
                end
            end
        end
        w_next = w_g[SCAN_LVLS] & i_view.row_mask;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prefix <= w_next[i_view.len];
            r_alive  <= |w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_row   <= w_next;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_prefix_matches = r_prefix;
    assign o_any_alive      = r_alive;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the wildcard pattern matcher stream block
`default_nettype none

module tb
    import wpm_pkg::*;
();

    localparam int NUM_REGS       = 5;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [7:0] CH_A   = 8'h61;

    typedef struct packed {
        logic any_alive;
        logic prefix_matches;
    } match_word_t;

    // predicts the match row per text byte and keeps the words still due
    class match_scoreboard;
        logic [LEN_W-1:0]      len_reg;
        logic [CFG_DATA_W-1:0] words [4];
        logic [ROW_W-1:0]      row;
        bit                    at_start;
        match_word_t           due_words [$];
        int                    errors;

        function new();
            len_reg  = '0;
            for (int i = 0; i < 4; i++) words[i] = '0;
            row      = '0;
            at_start = 1'b1;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PATTERN_LENGTH: len_reg  = val[LEN_W-1:0];
                REG_BYTES_LOW:      words[0] = val;
                REG_BYTES_SECOND:   words[1] = val;
                REG_BYTES_THIRD:    words[2] = val;
                REG_BYTES_HIGH:     words[3] = val;
                default: ;
            endcase
        endfunction

        function logic [7:0] pat_at(int pos);
            return words[pos / WORD_BYTES][(pos % WORD_BYTES) * 8 +: 8];
        endfunction

        function void note_byte(logic [7:0] c, logic first);
            int               len;
            logic [ROW_W-1:0] prev;
            logic [ROW_W-1:0] nxt;
            logic [7:0]       p;
            match_word_t      w;
            len = (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
            if (first || at_start) begin
                // restart row: position 0 plus every leading star
                prev    = '0;
                prev[0] = 1'b1;
                for (int j = 0; j < len; j++) begin
                    if (pat_at(j) != STAR_BYTE) break;
                    prev[j + 1] = 1'b1;
                end
            end else begin
                prev = row;
            end
            for (int j = len + 1; j < ROW_W; j++) prev[j] = 1'b0;
            at_start = 1'b0;
            nxt = '0;
            for (int j = 1; j <= len; j++) begin
                p = pat_at(j - 1);
                if (p == STAR_BYTE)
                    nxt[j] = prev[j] | nxt[j - 1];
                else if (p == ANY_BYTE || p == c)
                    nxt[j] = prev[j - 1];
            end
            row              = nxt;
            w.prefix_matches = nxt[len];
            w.any_alive      = |nxt;
            due_words.push_back(w);
        endfunction

        function void check_word(logic [7:0] data);
            match_word_t w;
            if (due_words.size() == 0) begin
                $error("unexpected result word %02h", data);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (data[0] !== w.prefix_matches) begin
                $error("prefix_matches: expected %0b, actual %0b", w.prefix_matches, data[0]);
                errors++;
            end
            if (data[1] !== w.any_alive) begin
                $error("any_alive: expected %0b, actual %0b", w.any_alive, data[1]);
                errors++;
            end
            if (data[7:2] !== '0) begin
                $error("tdata pad: expected 0, actual %02h", data[7:2]);
                errors++;
            end
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata;
    logic [0:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [7:0]            o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    match_scoreboard sb = new();
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  send_gaps   = 1'b0;
    bit  stall_on    = 1'b0;
    bit  hold_req    = 1'b0;

    wildcard_pattern_matcher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return CH_A + 8'($urandom_range(0, 2));
            5:             return STAR_BYTE;
            6:             return ANY_BYTE;
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pattern_char();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return CH_A + 8'($urandom_range(0, 2));
            4, 5:       return STAR_BYTE;
            default:    return ANY_BYTE;
        endcase
    endfunction

    function automatic logic [PAT_W-1:0] pack_str(string s);
        logic [PAT_W-1:0] r;
        r = '0;
        for (int i = 0; i < s.len(); i++) r[8 * i +: 8] = s[i];
        return r;
    endfunction

    // result side and watchdog
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("wildcard_pattern_matcher verification failed");
            $finish;
        end
    end

    initial begin : result_sink
        int n;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                // long hold so the queue fills and input backs up
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic f);
        int gap;
        gap = (send_gaps && $urandom_range(0, 3) == 0) ? gap_len() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(c, f);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_pattern(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat,
                               input bit junk);
        drain();
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_BYTES_LOW,    pat[0 +: CFG_DATA_W]);
        write_reg(REG_BYTES_SECOND, pat[CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_BYTES_THIRD,  pat[2 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_BYTES_HIGH,   pat[3 * CFG_DATA_W +: CFG_DATA_W]);
        // indexes past the last register must be ignored
        if (junk)
            write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(0, 2)), {$urandom, $urandom});
    endtask

    task automatic pick_pattern(output logic [LEN_W-1:0] len, output logic [PAT_W-1:0] pat);
        for (int i = 0; i < MAX_PATTERN; i++) pat[8 * i +: 8] = pattern_char();
        case ($urandom_range(0, 9))
            0: begin
                pat = {MAX_PATTERN{STAR_BYTE}};
                len = LEN_W'($urandom_range(1, MAX_PATTERN));
            end
            1: begin
                pat = {MAX_PATTERN{ANY_BYTE}};
                len = LEN_W'(MAX_PATTERN);
            end
            2: begin
                for (int i = 0; i < MAX_PATTERN / 4; i++) pat[32 * i +: 32] = $urandom;
                len = LEN_W'($urandom_range(0, 63));
            end
            3: len = LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
            4: len = '0;
            default: len = LEN_W'($urandom_range(1, 12));
        endcase
    endtask

    // one text: mostly shaped after the pattern, sometimes broken or pure noise
    task automatic send_text(input logic [LEN_W-1:0] len, input logic [PAT_W-1:0] pat);
        logic [7:0] txt [$];
        logic [7:0] p;
        int         eff;
        eff = (len > MAX_PATTERN) ? MAX_PATTERN : int'(len);
        if ($urandom_range(0, 9) < 7) begin
            for (int j = 0; j < eff; j++) begin
                p = pat[8 * j +: 8];
                if (p == STAR_BYTE)
                    repeat ($urandom_range(0, 3)) txt.push_back(text_byte());
                else if (p == ANY_BYTE)
                    txt.push_back(text_byte());
                else
                    txt.push_back(p);
            end
            if (txt.size() > 0 && $urandom_range(0, 4) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = text_byte();
            if ($urandom_range(0, 5) == 0)
                txt.push_back(text_byte());
        end else begin
            repeat ($urandom_range(1, 10)) txt.push_back(text_byte());
        end
        if (txt.size() == 0)
            txt.push_back(text_byte());
        // now and then a text carries on from the previous row
        for (int i = 0; i < txt.size(); i++)
            push_byte(txt[i], (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0);
    endtask

    initial begin : stimulus
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] pat;
        int               phase;
        int               target;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // leading stars, literal star and question mark in the text
        set_pattern(LEN_W'(6), pack_str("**a?*b"), 1'b0);
        push_byte("a", 1'b0);
        push_byte("x", 1'b0);
        push_byte("b", 1'b0);
        push_byte("b", 1'b0);
        push_byte(STAR_BYTE, 1'b1);
        push_byte("a", 1'b0);
        push_byte(ANY_BYTE, 1'b0);
        push_byte(STAR_BYTE, 1'b0);
        push_byte("b", 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        // empty pattern never matches a nonempty text
        set_pattern(LEN_W'(0), '1, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte("a", 1'b0);
        // oversize length clamps to the full pattern
        set_pattern(6'h3F, {MAX_PATTERN{ANY_BYTE}}, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(STAR_BYTE, 1'b0);
        set_pattern(LEN_W'(MAX_PATTERN), {MAX_PATTERN{STAR_BYTE}}, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        set_pattern(LEN_W'(1), '1, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b1);

        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            pick_pattern(len, pat);
            set_pattern(len, pat, $urandom_range(0, 3) == 0);
            send_gaps = (phase % 3) != 0;
            stall_on  = (phase % 4) != 1;
            if (phase == 0) begin
                send_gaps = 1'b0;
                hold_req  = 1'b1;
            end
            repeat ($urandom_range(20, 40)) begin
                if (items_sent < target) send_text(len, pat);
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("wildcard_pattern_matcher verification clean");
        end else begin
            $display("wildcard_pattern_matcher verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
